// File: design/pip_pkg.sv
// Shared constants and request/result types of the point-in-polygon test unit.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [5:0]                vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_req_t;

  typedef struct packed {
    logic       inside_res;
    logic [6:0] crossing_count;
  } out_res_t;

endpackage

// File: design/pip_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit with vertex table and crossing pipeline.
//
// A request is taken when start is high and busy is low. A vertex write request
// (func low) stores coord_x and coord_y in the vertex table slot vertex_index and
// is done in that cycle; busy stays low and no result follows. A query request
// (func high) tests the point against the polygon of the first vertex_count
// vertices, with the count limited to the table depth.
// The query reads one vertex per cycle from the table RAM, then forms the closing
// edge back to vertex zero; each edge passes a three-stage compute pipeline that
// checks the straddle, multiplies and compares, while the bounding box is built
// in the same pass. The result appears on out_res with out_strobe high for one
// cycle, and busy drops in that same cycle, so the next request can be taken
// at the edge that ends it.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// Reset clears vertex_count and the control state; the vertex table is not
// cleared and must be written before a query reads it.
module point_in_polygon_test_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pip_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output pip_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);

  localparam int AW = pip_pkg::ADDR_W;
  localparam int CW = pip_pkg::CNT_W;
  localparam int XW = pip_pkg::COORD_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CLOSE = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [6:0]    vertex_count_r;
  logic [CW-1:0] n_r, n_sat;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          empty_r, empty_nxt;
  logic signed [XW-1:0] px_r, py_r;

  logic          accept, wr_en, query;
  logic [2*XW-1:0] rdata;

  logic          rd_vld_r, rd_first_r, rd_close_r;
  logic signed [XW-1:0] v0x_r, v0y_r, prevx_r, prevy_r;
  logic signed [XW-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic signed [XW-1:0] curx, cury;
  logic          edge_vld, straddle;
  logic signed [XW:0] dy_c, dxp_c, dyp_c, dxb_c;

  logic          e_vld_r, e_last_r, e_str_r, e_dypos_r;
  logic signed [XW:0] e_dy_r, e_dxp_r, e_dyp_r, e_dxb_r;

  logic          m_vld_r, m_last_r, m_str_r, m_dypos_r;
  logic signed [2*XW+1:0] m_lhs_r, m_rhs_r;

  logic          hit;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          inbox;
  logic          out_strobe_r;
  pip_pkg::out_res_t out_res_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (in_req.func == pip_pkg::FUNC_WRITE) &&
                  (32'(in_req.vertex_index) < pip_pkg::MAX_VERTICES);
  assign query  = accept && (in_req.func == pip_pkg::FUNC_QUERY);
  assign n_sat  = (32'(vertex_count_r) > pip_pkg::MAX_VERTICES) ?
                  CW'(pip_pkg::MAX_VERTICES) : CW'(vertex_count_r);

  pip_ram #(
    .WIDTH(2 * XW),
    .DEPTH(pip_pkg::MAX_VERTICES)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(in_req.vertex_index)),
    .wdata({in_req.coord_x, in_req.coord_y}),
    .raddr(idx_r),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    empty_nxt = empty_r;
    case (state_r)
      S_IDLE: begin
        if (query) begin
          idx_nxt   = '0;
          empty_nxt = (n_sat == '0);
          state_nxt = (n_sat == '0) ? S_CLOSE : S_READ;
        end
      end
      S_READ: begin
        idx_nxt = idx_r + AW'(1);
        if (CW'(idx_r) == n_r - CW'(1)) begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (m_vld_r && m_last_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    curx     = rd_close_r ? v0x_r : $signed(rdata[2*XW-1:XW]);
    cury     = rd_close_r ? v0y_r : $signed(rdata[XW-1:0]);
    edge_vld = (rd_vld_r && !rd_first_r) || rd_close_r;
    straddle = ((prevy_r <= py_r) && (cury > py_r)) ||
               ((cury <= py_r) && (prevy_r > py_r));
    dy_c     = (XW+1)'(cury) - (XW+1)'(prevy_r);
    dxp_c    = (XW+1)'(px_r) - (XW+1)'(prevx_r);
    dyp_c    = (XW+1)'(py_r) - (XW+1)'(prevy_r);
    dxb_c    = (XW+1)'(curx) - (XW+1)'(prevx_r);
  end

  always_comb begin
    hit     = m_vld_r && m_str_r &&
              (m_dypos_r ? (m_lhs_r < m_rhs_r) : (m_lhs_r > m_rhs_r));
    cnt_nxt = hit ? cnt_r + CW'(1) : cnt_r;
    inbox   = !empty_r && (px_r >= minx_r) && (px_r <= maxx_r) &&
              (py_r >= miny_r) && (py_r <= maxy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      vertex_count_r <= '0;
      idx_r          <= '0;
      empty_r        <= 1'b0;
      rd_vld_r       <= 1'b0;
      rd_first_r     <= 1'b0;
      rd_close_r     <= 1'b0;
      e_vld_r        <= 1'b0;
      e_last_r       <= 1'b0;
      m_vld_r        <= 1'b0;
      m_last_r       <= 1'b0;
      cnt_r          <= '0;
      out_strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      empty_r    <= empty_nxt;
      if (cfg_we) begin
        vertex_count_r <= cfg_wdata;
      end
      rd_vld_r   <= (state_r == S_READ);
      rd_first_r <= (state_r == S_READ) && (idx_r == '0);
      rd_close_r <= (state_r == S_CLOSE);
      e_vld_r    <= edge_vld;
      e_last_r   <= rd_close_r;
      m_vld_r    <= e_vld_r;
      m_last_r   <= e_last_r;
      if (query) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
      out_strobe_r <= m_vld_r && m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (query) begin
      n_r  <= n_sat;
      px_r <= in_req.coord_x;
      py_r <= in_req.coord_y;
    end
    if (rd_vld_r || rd_close_r) begin
      prevx_r <= curx;
      prevy_r <= cury;
    end
    if (rd_vld_r && rd_first_r) begin
      v0x_r  <= curx;
      v0y_r  <= cury;
      minx_r <= curx;
      maxx_r <= curx;
      miny_r <= cury;
      maxy_r <= cury;
    end else if (rd_vld_r) begin
      if (curx < minx_r) minx_r <= curx;
      if (curx > maxx_r) maxx_r <= curx;
      if (cury < miny_r) miny_r <= cury;
      if (cury > maxy_r) maxy_r <= cury;
    end
    e_str_r   <= straddle;
    e_dypos_r <= (cury > prevy_r);
    e_dy_r    <= dy_c;
    e_dxp_r   <= dxp_c;
    e_dyp_r   <= dyp_c;
    e_dxb_r   <= dxb_c;
    m_str_r   <= e_str_r;
    m_dypos_r <= e_dypos_r;
    m_lhs_r   <= e_dxp_r * e_dy_r;
    m_rhs_r   <= e_dyp_r * e_dxb_r;
    if (m_vld_r && m_last_r) begin
      out_res_r.inside_res     <= inbox && cnt_nxt[0];
      out_res_r.crossing_count <= inbox ? 7'(cnt_nxt) : 7'd0;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the point-in-polygon test unit with directed and random polygons.
module testbench;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CFG_PAUSE      = 8;
  localparam int SETTLE_CYCLES  = 80;
  localparam int TOTAL_REQUESTS = 550;
  localparam int COORD_MIN      = -32768;
  localparam int COORD_MAX      = 32767;
  localparam int STYLE_FULL     = 0;
  localparam int STYLE_GRID     = 1;
  localparam int STYLE_CLUSTER  = 2;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pip_pkg::in_req_t  in_req;
  logic              out_strobe;
  pip_pkg::out_res_t out_res;
  logic              cfg_we;
  logic [6:0]        cfg_wdata;

  int                poly_x [pip_pkg::MAX_VERTICES];
  int                poly_y [pip_pkg::MAX_VERTICES];
  logic [6:0]        poly_count;
  pip_pkg::out_res_t expected_results[$];
  pip_pkg::out_res_t expected_head;
  bit                no_gaps;
  int                mismatches;
  int                stall_cycles;
  int                requests_accepted;
  int                vertex_writes;
  int                queries_sent;
  int                inside_predicted;
  int                count_settings;

  point_in_polygon_test_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int random_coord(input int style, input int center);
    case (style)
      STYLE_GRID:    return rand_between(-6, 6);
      STYLE_CLUSTER: return clamp_coord(center + rand_between(-1000, 1000));
      default:       return rand_between(COORD_MIN, COORD_MAX);
    endcase
  endfunction

  function automatic int effective_count();
    return (poly_count > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : int'(poly_count);
  endfunction

  function automatic void polygon_bounds(input int n, output int min_x, output int max_x,
                                         output int min_y, output int max_y);
    min_x = poly_x[0];
    max_x = poly_x[0];
    min_y = poly_y[0];
    max_y = poly_y[0];
    for (int i = 1; i < n; i++) begin
      if (poly_x[i] < min_x) min_x = poly_x[i];
      if (poly_x[i] > max_x) max_x = poly_x[i];
      if (poly_y[i] < min_y) min_y = poly_y[i];
      if (poly_y[i] > max_y) max_y = poly_y[i];
    end
  endfunction

  // Even-odd crossing count; the crossing test multiplies through by the edge's dy.
  function automatic pip_pkg::out_res_t predict_query(input int px, input int py);
    int                n, j, hits;
    int                min_x, max_x, min_y, max_y;
    longint            dy, lhs, rhs;
    bit                straddles;
    pip_pkg::out_res_t res;
    n = effective_count();
    hits = 0;
    if (n != 0) begin
      polygon_bounds(n, min_x, max_x, min_y, max_y);
      if (px >= min_x && px <= max_x && py >= min_y && py <= max_y) begin
        for (int i = 0; i < n; i++) begin
          j = (i + 1 == n) ? 0 : i + 1;
          straddles = (poly_y[i] <= py && poly_y[j] > py) ||
                      (poly_y[j] <= py && poly_y[i] > py);
          if (straddles) begin
            dy  = longint'(poly_y[j]) - poly_y[i];
            lhs = (longint'(px) - poly_x[i]) * dy;
            rhs = (longint'(py) - poly_y[i]) * (longint'(poly_x[j]) - poly_x[i]);
            if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) hits++;
          end
        end
      end
    end
    res.inside_res     = hits[0];
    res.crossing_count = hits[6:0];
    return res;
  endfunction

  task automatic issue_request(input pip_pkg::in_req_t r);
    int                gap;
    pip_pkg::out_res_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    requests_accepted++;
    if (r.func == pip_pkg::FUNC_WRITE) begin
      poly_x[r.vertex_index] = int'($signed(r.coord_x));
      poly_y[r.vertex_index] = int'($signed(r.coord_y));
      vertex_writes++;
    end else begin
      res = predict_query(int'($signed(r.coord_x)), int'($signed(r.coord_y)));
      expected_results.push_back(res);
      queries_sent++;
      if (res.inside_res) inside_predicted++;
    end
  endtask

  task automatic write_vertex(input int slot, input int x, input int y);
    pip_pkg::in_req_t r;
    r.func         = pip_pkg::FUNC_WRITE;
    r.vertex_index = slot[5:0];
    r.coord_x      = 16'(x);
    r.coord_y      = 16'(y);
    issue_request(r);
  endtask

  task automatic query_point(input int x, input int y);
    pip_pkg::in_req_t r;
    r.func         = pip_pkg::FUNC_QUERY;
    r.vertex_index = 6'($urandom_range(0, 63));
    r.coord_x      = 16'(x);
    r.coord_y      = 16'(y);
    issue_request(r);
  endtask

  // The unit must be idle, so all pending results are drained first.
  task automatic set_vertex_count(input logic [6:0] value);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    poly_count  = value;
    count_settings++;
  endtask

  task automatic random_query();
    int n, pick, k, x, y;
    int min_x, max_x, min_y, max_y;
    n = effective_count();
    pick = $urandom_range(0, 9);
    if (n == 0 || pick == 7) begin
      x = rand_between(COORD_MIN, COORD_MAX);
      y = rand_between(COORD_MIN, COORD_MAX);
    end else begin
      polygon_bounds(n, min_x, max_x, min_y, max_y);
      x = rand_between(min_x, max_x);
      y = rand_between(min_y, max_y);
      k = $urandom_range(0, n - 1);
      if (pick == 5) begin
        y = poly_y[k];
      end else if (pick == 6) begin
        x = poly_x[k];
        y = poly_y[k];
      end else if (pick == 8) begin
        x = clamp_coord($urandom_range(0, 1) ? max_x + 1 : min_x - 1);
      end else if (pick == 9) begin
        y = clamp_coord($urandom_range(0, 1) ? max_y + 1 : min_y - 1);
      end
    end
    query_point(x, y);
  endtask

  task automatic test_empty_polygon();
    query_point(COORD_MIN, COORD_MAX);
    query_point(COORD_MAX, COORD_MIN);
  endtask

  task automatic test_square();
    write_vertex(0, -100, -100);
    write_vertex(1, 100, -100);
    write_vertex(2, 100, 100);
    write_vertex(3, -100, 100);
    set_vertex_count(7'd4);
    query_point(0, 0);
    query_point(200, 0);
    query_point(-100, 0);
    query_point(100, 0);
    query_point(0, -100);
    query_point(0, 100);
    query_point(-101, 50);
  endtask

  task automatic test_extreme_coords();
    write_vertex(0, COORD_MIN, COORD_MIN);
    write_vertex(1, COORD_MAX, COORD_MIN);
    write_vertex(2, 0, COORD_MAX);
    write_vertex(63, COORD_MAX, COORD_MAX);
    set_vertex_count(7'd3);
    query_point(COORD_MIN, COORD_MIN);
    query_point(COORD_MAX, COORD_MAX);
    query_point(0, 0);
    query_point(-1, COORD_MAX - 1);
    query_point(COORD_MAX, COORD_MIN);
  endtask

  task automatic test_count_saturation();
    logic [6:0] counts[3] = '{7'd64, 7'd65, 7'd127};
    int         center_x, center_y;
    center_x = rand_between(-30000, 30000);
    center_y = rand_between(-30000, 30000);
    for (int i = 0; i < pip_pkg::MAX_VERTICES; i++)
      write_vertex(i, random_coord(STYLE_CLUSTER, center_x),
                   random_coord(STYLE_CLUSTER, center_y));
    foreach (counts[k]) begin
      set_vertex_count(counts[k]);
      repeat (5) random_query();
    end
  endtask

  task automatic test_random_polygons();
    int n, style, center_x, center_y, queries;
    while (requests_accepted < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 19))
        0:       n = 0;
        1:       n = 1;
        2:       n = 2;
        3:       n = pip_pkg::MAX_VERTICES;
        default: n = $urandom_range(3, 12);
      endcase
      style    = $urandom_range(STYLE_FULL, STYLE_CLUSTER);
      center_x = rand_between(-31000, 31000);
      center_y = rand_between(-31000, 31000);
      no_gaps  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++)
        write_vertex(i, random_coord(style, center_x), random_coord(style, center_y));
      set_vertex_count((n == pip_pkg::MAX_VERTICES) ?
                       7'($urandom_range(pip_pkg::MAX_VERTICES, 127)) : 7'(n));
      queries = $urandom_range(8, 20);
      for (int q = 0; q < queries; q++) begin
        if (n != 0 && $urandom_range(0, 7) == 0)
          write_vertex($urandom_range(0, n - 1), random_coord(style, center_x),
                       random_coord(style, center_y));
        random_query();
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result at %0t: inside=%0b crossings=%0d",
                   $time, out_res.inside_res, out_res.crossing_count);
      end else begin
        expected_head = expected_results.pop_front();
        if (out_res.inside_res !== expected_head.inside_res ||
            out_res.crossing_count !== expected_head.crossing_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected inside=%0b crossings=%0d, %s",
                     $time, expected_head.inside_res, expected_head.crossing_count,
                     "got", " inside=%0b crossings=%0d",
                     out_res.inside_res, out_res.crossing_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_req            = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    poly_count        = '0;
    no_gaps           = 1'b0;
    mismatches        = 0;
    stall_cycles      = 0;
    requests_accepted = 0;
    vertex_writes     = 0;
    queries_sent      = 0;
    inside_predicted  = 0;
    count_settings    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_polygon();
    test_square();
    test_extreme_coords();
    test_count_saturation();
    test_random_polygons();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d vertex writes and %0d point queries, %0d of them predicted inside.",
             vertex_writes, queries_sent, inside_predicted);
    $display("The vertex count was set %0d times, from an empty polygon up to saturated counts.",
             count_settings);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
design/pip_pkg.sv
design/pip_ram.sv
design/point_in_polygon_test_unit.sv
tb/testbench.sv
